// File: design/touch_point_filter_calibrate_unit_assert.svh
`ifndef TOUCH_POINT_FILTER_CALIBRATE_UNIT_ASSERT_SVH
`define TOUCH_POINT_FILTER_CALIBRATE_UNIT_ASSERT_SVH

// Check that a condition holds in the same cycle as its trigger
`define TPFC_ASSERT_SAME(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Check that a condition holds in the cycle after its trigger
`define TPFC_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// File: design/tpfc_pkg.sv
`default_nettype none

package tpfc_pkg;

   // Filter shape
   localparam int DEBOUNCE_POLLS_INT = 1;
   localparam int TRIM_SHIFT = 3;
   localparam logic [3:0] DEBOUNCE_POLLS = 4'(DEBOUNCE_POLLS_INT);
   localparam logic [5:0] SAMPLE_COUNT = 6'((1 << TRIM_SHIFT) + 2);

   // Datapath widths
   localparam int RAW_W = 12;
   localparam int SUM_W = 18;
   localparam int SIZE_W = 13;
   localparam int PROD_W = 45;
   localparam int ACC_W = 47;
   localparam int FRAC_W = 16;
   localparam int ADDR_W = 5;

   localparam logic [SIZE_W-1:0] SIZE_MAX = 13'd4096;

   // Register map, one word per register
   typedef enum logic [2:0] {
      CSR_COEF_XX       = 3'd0,
      CSR_COEF_XY       = 3'd1,
      CSR_OFFSET_X      = 3'd2,
      CSR_COEF_YX       = 3'd3,
      CSR_COEF_YY       = 3'd4,
      CSR_OFFSET_Y      = 3'd5,
      CSR_SCREEN_WIDTH  = 3'd6,
      CSR_SCREEN_HEIGHT = 3'd7
   } csr_index_type;

   typedef struct packed {
      logic signed [31:0] coef_xx;
      logic signed [31:0] coef_xy;
      logic signed [31:0] offset_x;
      logic signed [31:0] coef_yx;
      logic signed [31:0] coef_yy;
      logic signed [31:0] offset_y;
      logic [SIZE_W-1:0]  screen_width;
      logic [SIZE_W-1:0]  screen_height;
   } cfg_type;

   typedef struct packed {
      logic             fire;
      logic [RAW_W-1:0] mean_x;
      logic [RAW_W-1:0] mean_y;
   } gather_type;

   // Map a programmed screen size into 1..4096
   function automatic logic [SIZE_W-1:0] size_limit(input logic [SIZE_W-1:0] size);
      logic [SIZE_W-1:0] lim;
      if (size == '0) begin
         lim = SIZE_W'(1);
      end else if (size > SIZE_MAX) begin
         lim = SIZE_MAX;
      end else begin
         lim = size;
      end
      return lim;
   endfunction

endpackage

`default_nettype wire

// File: design/tpfc_req_if.sv
`default_nettype none

interface tpfc_req_if;
   import tpfc_pkg::*;

   logic             valid;
   logic             ready;
   logic             pen_down;
   logic [RAW_W-1:0] raw_x;
   logic [RAW_W-1:0] raw_y;

   modport source (output valid, output pen_down, output raw_x, output raw_y, input ready);
   modport sink (input valid, input pen_down, input raw_x, input raw_y, output ready);
endinterface

`default_nettype wire

// File: design/tpfc_rsp_if.sv
`default_nettype none

interface tpfc_rsp_if;
   import tpfc_pkg::*;

   logic             valid;
   logic             ready;
   logic [RAW_W-1:0] touch_x;
   logic [RAW_W-1:0] touch_y;

   modport source (output valid, output touch_x, output touch_y, input ready);
   modport sink (input valid, input touch_x, input touch_y, output ready);
endinterface

`default_nettype wire

// File: design/tpfc_gather.sv
`default_nettype none

module tpfc_gather (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire logic                       step,
   input  wire logic                       pen_down,
   input  wire logic [tpfc_pkg::RAW_W-1:0] raw_x,
   input  wire logic [tpfc_pkg::RAW_W-1:0] raw_y,
   output tpfc_pkg::gather_type            result
);
   import tpfc_pkg::*;

   logic [3:0]       debounce_ff, debounce_in;
   logic             sent_ff, sent_in;
   logic [5:0]       taken_ff, taken_in;
   logic [SUM_W-1:0] sum_x_ff, sum_x_in;
   logic [SUM_W-1:0] sum_y_ff, sum_y_in;
   logic [RAW_W-1:0] low_x_ff, low_x_in;
   logic [RAW_W-1:0] high_x_ff, high_x_in;
   logic [RAW_W-1:0] low_y_ff, low_y_in;
   logic [RAW_W-1:0] high_y_ff, high_y_in;

   logic             first;
   logic             collect;
   logic             done;
   logic [5:0]       taken_next;
   logic [SUM_W-1:0] sum_x_next, sum_y_next;
   logic [SUM_W-1:0] trim_x, trim_y;

   // Running extremes and sums including the current sample
   always_comb begin
      first      = (taken_ff == '0);
      low_x_in   = (first || raw_x < low_x_ff) ? raw_x : low_x_ff;
      high_x_in  = (first || raw_x > high_x_ff) ? raw_x : high_x_ff;
      low_y_in   = (first || raw_y < low_y_ff) ? raw_y : low_y_ff;
      high_y_in  = (first || raw_y > high_y_ff) ? raw_y : high_y_ff;
      sum_x_next = sum_x_ff + SUM_W'(raw_x);
      sum_y_next = sum_y_ff + SUM_W'(raw_y);
      taken_next = taken_ff + 6'd1;
      collect    = pen_down && (debounce_ff >= DEBOUNCE_POLLS) && !sent_ff;
      done       = collect && (taken_next == SAMPLE_COUNT);
      trim_x     = sum_x_next - SUM_W'(low_x_in) - SUM_W'(high_x_in);
      trim_y     = sum_y_next - SUM_W'(low_y_in) - SUM_W'(high_y_in);
   end

   assign result.fire   = step && done;
   assign result.mean_x = RAW_W'(trim_x >> TRIM_SHIFT);
   assign result.mean_y = RAW_W'(trim_y >> TRIM_SHIFT);

   // Next state of the press tracker
   always_comb begin
      debounce_in = debounce_ff;
      sent_in     = sent_ff;
      taken_in    = taken_ff;
      sum_x_in    = sum_x_ff;
      sum_y_in    = sum_y_ff;
      if (!pen_down) begin
         debounce_in = '0;
         sent_in     = 1'b0;
         taken_in    = '0;
         sum_x_in    = '0;
         sum_y_in    = '0;
      end else if (debounce_ff < DEBOUNCE_POLLS) begin
         debounce_in = debounce_ff + 4'd1;
      end else if (done) begin
         sent_in  = 1'b1;
         taken_in = '0;
         sum_x_in = '0;
         sum_y_in = '0;
      end else if (collect) begin
         taken_in = taken_next;
         sum_x_in = sum_x_next;
         sum_y_in = sum_y_next;
      end
   end

   // Control state
   always_ff @(posedge clock) begin
      if (reset) begin
         debounce_ff <= '0;
         sent_ff     <= 1'b0;
         taken_ff    <= '0;
         sum_x_ff    <= '0;
         sum_y_ff    <= '0;
      end else if (step) begin
         debounce_ff <= debounce_in;
         sent_ff     <= sent_in;
         taken_ff    <= taken_in;
         sum_x_ff    <= sum_x_in;
         sum_y_ff    <= sum_y_in;
      end
   end

   // Extremes are written by the first sample before they are read
   always_ff @(posedge clock) begin
      if (step && collect) begin
         low_x_ff  <= low_x_in;
         high_x_ff <= high_x_in;
         low_y_ff  <= low_y_in;
         high_y_ff <= high_y_in;
      end
   end

endmodule

`default_nettype wire

// File: design/tpfc_map.sv
`default_nettype none

module tpfc_map (
   input  wire logic                       clock,
   input  wire logic                       load,
   input  wire logic [tpfc_pkg::RAW_W-1:0] mean_x,
   input  wire logic [tpfc_pkg::RAW_W-1:0] mean_y,
   input  wire tpfc_pkg::cfg_type          cfg,
   output logic [tpfc_pkg::RAW_W-1:0]      touch_x,
   output logic [tpfc_pkg::RAW_W-1:0]      touch_y
);
   import tpfc_pkg::*;

   logic signed [PROD_W-1:0] prod_xx_ff, prod_xy_ff, prod_yx_ff, prod_yy_ff;
   logic signed [PROD_W-1:0] prod_xx_in, prod_xy_in, prod_yx_in, prod_yy_in;
   logic signed [PROD_W-1:0] mx_wide, my_wide;
   logic signed [ACC_W-1:0]  acc_x, acc_y;
   logic signed [ACC_W-FRAC_W-1:0] floor_x, floor_y;
   logic [SIZE_W-1:0]        lim_x, lim_y;

   // Four 32x13 products, registered before the sum
   always_comb begin
      mx_wide    = $signed({{(PROD_W-RAW_W){1'b0}}, mean_x});
      my_wide    = $signed({{(PROD_W-RAW_W){1'b0}}, mean_y});
      prod_xx_in = PROD_W'(cfg.coef_xx) * mx_wide;
      prod_xy_in = PROD_W'(cfg.coef_xy) * my_wide;
      prod_yx_in = PROD_W'(cfg.coef_yx) * mx_wide;
      prod_yy_in = PROD_W'(cfg.coef_yy) * my_wide;
   end

   always_ff @(posedge clock) begin
      if (load) begin
         prod_xx_ff <= prod_xx_in;
         prod_xy_ff <= prod_xy_in;
         prod_yx_ff <= prod_yx_in;
         prod_yy_ff <= prod_yy_in;
      end
   end

   // Sum, floor to whole pixels, clamp into the screen
   always_comb begin
      acc_x   = ACC_W'(prod_xx_ff) + ACC_W'(prod_xy_ff) + ACC_W'(cfg.offset_x);
      acc_y   = ACC_W'(prod_yx_ff) + ACC_W'(prod_yy_ff) + ACC_W'(cfg.offset_y);
      floor_x = acc_x[ACC_W-1:FRAC_W];
      floor_y = acc_y[ACC_W-1:FRAC_W];
      lim_x   = size_limit(cfg.screen_width);
      lim_y   = size_limit(cfg.screen_height);
      if (floor_x < 0) begin
         touch_x = '0;
      end else if (floor_x >= $signed({{(ACC_W-FRAC_W-SIZE_W){1'b0}}, lim_x})) begin
         touch_x = RAW_W'(lim_x - SIZE_W'(1));
      end else begin
         touch_x = floor_x[RAW_W-1:0];
      end
      if (floor_y < 0) begin
         touch_y = '0;
      end else if (floor_y >= $signed({{(ACC_W-FRAC_W-SIZE_W){1'b0}}, lim_y})) begin
         touch_y = RAW_W'(lim_y - SIZE_W'(1));
      end else begin
         touch_y = floor_y[RAW_W-1:0];
      end
   end

endmodule

`default_nettype wire

// File: design/touch_point_filter_calibrate_unit.sv
// Channel  Direction  Payload                       Handshake
// req      in         pen_down, raw_x[11:0], raw_y  valid / ready
// rsp      out        touch_x[11:0], touch_y[11:0]  valid / ready
// csr      in         8 x 32-bit registers, APB     psel / penable, pready tied high
//
// One transaction is taken per cycle while the input stage is free; the four stage
// registers (input, trimmed mean, products, result) carry the press whose sample set
// a transaction completes, in that order, before its result is presented on rsp.
// Reset is synchronous: it clears stage valids, the press tracker and restores
// the calibration registers.
// Each stage holds only while the stage after it is full and stalled, so req
// keeps flowing while a result waits on rsp, until the mean and product stages also hold presses.
`default_nettype none

module touch_point_filter_calibrate_unit (
   input  wire logic                        clock,
   input  wire logic                        reset,
   tpfc_req_if.sink                         req,
   tpfc_rsp_if.source                       rsp,
   input  wire logic                        psel,
   input  wire logic                        penable,
   input  wire logic                        pwrite,
   input  wire logic [tpfc_pkg::ADDR_W-1:0] paddr,
   input  wire logic [31:0]                 pwdata,
   output logic [31:0]                      prdata,
   output logic                             pready
);
   import tpfc_pkg::*;

   cfg_type          cfg_ff, cfg_in;
   csr_index_type    csr_index;
   logic             csr_write;

   logic             s0_v_ff, s0_v_in;
   logic             pen_ff;
   logic [RAW_W-1:0] raw_x_ff, raw_y_ff;
   logic             s1_v_ff, s1_v_in;
   logic [RAW_W-1:0] mean_x_ff, mean_y_ff;
   logic             s2_v_ff, s2_v_in;
   logic             rsp_v_ff, rsp_v_in;
   logic [RAW_W-1:0] touch_x_ff, touch_y_ff;
   logic [RAW_W-1:0] map_x, map_y;

   logic             s3_free, s2_free, s1_free, s0_free;
   logic             s2_adv, s1_adv, s0_adv, req_fire;
   gather_type       gather;

   // Register port
   assign pready    = 1'b1;
   assign csr_index = csr_index_type'(paddr[ADDR_W-1:2]);
   assign csr_write = psel && penable && pwrite;

   always_comb begin
      cfg_in = cfg_ff;
      prdata = '0;
      unique case (csr_index)
         CSR_COEF_XX: begin
            cfg_in.coef_xx = pwdata;
            prdata         = cfg_ff.coef_xx;
         end
         CSR_COEF_XY: begin
            cfg_in.coef_xy = pwdata;
            prdata         = cfg_ff.coef_xy;
         end
         CSR_OFFSET_X: begin
            cfg_in.offset_x = pwdata;
            prdata          = cfg_ff.offset_x;
         end
         CSR_COEF_YX: begin
            cfg_in.coef_yx = pwdata;
            prdata         = cfg_ff.coef_yx;
         end
         CSR_COEF_YY: begin
            cfg_in.coef_yy = pwdata;
            prdata         = cfg_ff.coef_yy;
         end
         CSR_OFFSET_Y: begin
            cfg_in.offset_y = pwdata;
            prdata          = cfg_ff.offset_y;
         end
         CSR_SCREEN_WIDTH: begin
            cfg_in.screen_width = pwdata[SIZE_W-1:0];
            prdata              = 32'(cfg_ff.screen_width);
         end
         CSR_SCREEN_HEIGHT: begin
            cfg_in.screen_height = pwdata[SIZE_W-1:0];
            prdata               = 32'(cfg_ff.screen_height);
         end
         default: begin
            cfg_in = cfg_ff;
            prdata = '0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.coef_xx       <= -32'sd424;
         cfg_ff.coef_xy       <= -32'sd4801;
         cfg_ff.offset_x      <= 32'sd18373544;
         cfg_ff.coef_yx       <= 32'sd4907;
         cfg_ff.coef_yy       <= 32'sd134;
         cfg_ff.offset_y      <= -32'sd428997;
         cfg_ff.screen_width  <= 13'd240;
         cfg_ff.screen_height <= 13'd320;
      end else if (csr_write) begin
         cfg_ff <= cfg_in;
      end
   end

   // Stage advance chain, from the result end backward
   always_comb begin
      s3_free  = !rsp_v_ff || rsp.ready;
      s2_adv   = s2_v_ff && s3_free;
      s2_free  = !s2_v_ff || s3_free;
      s1_adv   = s1_v_ff && s2_free;
      s1_free  = !s1_v_ff || s2_free;
      s0_adv   = s0_v_ff && s1_free;
      s0_free  = !s0_v_ff || s1_free;
      req_fire = req.valid && s0_free;
   end

   assign req.ready = s0_free;

   always_comb begin
      s0_v_in  = req_fire ? 1'b1 : (s0_adv ? 1'b0 : s0_v_ff);
      s1_v_in  = s0_adv ? gather.fire : (s1_adv ? 1'b0 : s1_v_ff);
      s2_v_in  = s1_adv ? 1'b1 : (s2_adv ? 1'b0 : s2_v_ff);
      rsp_v_in = s2_adv ? 1'b1 : (rsp.ready ? 1'b0 : rsp_v_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s0_v_ff  <= 1'b0;
         s1_v_ff  <= 1'b0;
         s2_v_ff  <= 1'b0;
         rsp_v_ff <= 1'b0;
      end else begin
         s0_v_ff  <= s0_v_in;
         s1_v_ff  <= s1_v_in;
         s2_v_ff  <= s2_v_in;
         rsp_v_ff <= rsp_v_in;
      end
   end

   // Capture the incoming transaction
   always_ff @(posedge clock) begin
      if (req_fire) begin
         pen_ff   <= req.pen_down;
         raw_x_ff <= req.raw_x;
         raw_y_ff <= req.raw_y;
      end
   end

   tpfc_gather u_gather (
      .clock    (clock),
      .reset    (reset),
      .step     (s0_adv),
      .pen_down (pen_ff),
      .raw_x    (raw_x_ff),
      .raw_y    (raw_y_ff),
      .result   (gather)
   );

   // Hold the trimmed means of a finished press
   always_ff @(posedge clock) begin
      if (gather.fire) begin
         mean_x_ff <= gather.mean_x;
         mean_y_ff <= gather.mean_y;
      end
   end

   tpfc_map u_map (
      .clock   (clock),
      .load    (s1_adv),
      .mean_x  (mean_x_ff),
      .mean_y  (mean_y_ff),
      .cfg     (cfg_ff),
      .touch_x (map_x),
      .touch_y (map_y)
   );

   // Result register
   always_ff @(posedge clock) begin
      if (s2_adv) begin
         touch_x_ff <= map_x;
         touch_y_ff <= map_y;
      end
   end

   assign rsp.valid   = rsp_v_ff;
   assign rsp.touch_x = touch_x_ff;
   assign rsp.touch_y = touch_y_ff;

`include "touch_point_filter_calibrate_unit_assert.svh"

   `TPFC_ASSERT_NEXT(a_mean_holds, s1_v_ff && !s2_free, s1_v_ff, "mean stage dropped a press")
   `TPFC_ASSERT_SAME(a_x_on_screen, rsp_v_ff,
      {1'b0, touch_x_ff} < size_limit(cfg_ff.screen_width), "touch_x off screen")
   `TPFC_ASSERT_SAME(a_y_on_screen, rsp_v_ff,
      {1'b0, touch_y_ff} < size_limit(cfg_ff.screen_height), "touch_y off screen")
   `TPFC_ASSERT_NEXT(a_result_kept, rsp_v_ff && !rsp.ready, rsp_v_ff && $stable(touch_x_ff),
      "waiting result lost")

endmodule

`default_nettype wire
